// File: src/pfa_pkg.sv
// Package for the page frame allocator: field widths, codes, enums and the
// structs passed between the controller, the frame chain and its cells.
// No dependencies.
package pfa_pkg;

  // Field widths of the channels.
  localparam int PID_W    = 16;
  localparam int SIZE_W   = 24;
  localparam int FBYTES_W = 16;
  localparam int COUNT_W  = 7;
  localparam int PAGE_W   = 6;
  localparam int STATUS_W = 2;

  // Operation codes on the input channel.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_MAP   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FAIL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FRAME_BYTES   = 1'b0;
  localparam logic CFG_FRAMES_IN_USE = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [FBYTES_W-1:0] FRAME_BYTES_RST   = 16'd16;
  localparam logic [COUNT_W-1:0]  FRAMES_IN_USE_RST = 7'd64;

  // Largest number of frames that can ever be handed out (result capacity).
  localparam logic [COUNT_W-1:0] FRAME_CAP = 7'd64;

  // Kind of walk that the token performs along the chain.
  typedef enum logic [1:0] {
    MODE_COUNT,
    MODE_ALLOC,
    MODE_FREE
  } pfa_mode_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_WAVE,
    ST_EMIT
  } pfa_state_t;

  // Link between neighboring cells: the walking token and its accumulator.
  typedef struct packed {
    logic               tok;
    logic [COUNT_W-1:0] acc;
  } pfa_link_t;

  // A page mapping raised by the cell that holds the token.
  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] frame;
    logic              last;
  } pfa_emit_t;

endpackage

// File: src/pfa_in_if.sv
// Input channel of the page frame allocator: valid/ready plus request fields.
// Depends on pfa_pkg.
interface pfa_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [pfa_pkg::PID_W-1:0]  process_id;
  logic [pfa_pkg::SIZE_W-1:0] memory_size;

  modport source (output valid, output operation, output process_id,
                  output memory_size, input ready);
  modport sink   (input valid, input operation, input process_id,
                  input memory_size, output ready);
endinterface

// File: src/pfa_out_if.sv
// Result channel of the page frame allocator: valid/ready plus result fields.
// Depends on pfa_pkg.
interface pfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [pfa_pkg::STATUS_W-1:0] status;
  logic [pfa_pkg::PAGE_W-1:0]   logical_page;
  logic [pfa_pkg::PAGE_W-1:0]   frame_number;
  logic [pfa_pkg::COUNT_W-1:0]  freed_count;
  logic                         last;

  modport source (output valid, output status, output logical_page,
                  output frame_number, output freed_count, output last,
                  input ready);
  modport sink   (input valid, input status, input logical_page,
                  input frame_number, input freed_count, input last,
                  output ready);
endinterface

// File: src/pfa_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on pfa_pkg.
interface pfa_cfg_if;
  logic                         valid;
  logic                         ready;
  logic                         index;
  logic [pfa_pkg::FBYTES_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/pfa_div.sv
// Restoring divider, one quotient bit per cycle, giving the page count
// rounded up. Depends on pfa_pkg.
module pfa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pfa_pkg::SIZE_W-1:0]   dividend,
  input  logic [pfa_pkg::FBYTES_W-1:0] divisor,
  output logic                         done,
  output logic [pfa_pkg::SIZE_W-1:0]   pages
);

  localparam int CNT_W = $clog2(pfa_pkg::SIZE_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [pfa_pkg::FBYTES_W-1:0] rem_r, rem_nxt;
  logic [pfa_pkg::SIZE_W-1:0]   quo_r, quo_nxt;
  logic [pfa_pkg::FBYTES_W-1:0] dsr_r, dsr_nxt;
  logic [pfa_pkg::FBYTES_W:0]   shifted;
  logic [pfa_pkg::FBYTES_W:0]   diff;
  logic                         ge;

  // One shift, compare and subtract step per cycle.
  always_comb begin
    shifted  = {rem_r, quo_r[pfa_pkg::SIZE_W-1]};
    diff     = shifted - {1'b0, dsr_r};
    ge       = (shifted >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = CNT_W'(pfa_pkg::SIZE_W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[pfa_pkg::FBYTES_W-1:0] : shifted[pfa_pkg::FBYTES_W-1:0];
      quo_nxt = {quo_r[pfa_pkg::SIZE_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  // A nonzero remainder rounds the quotient up.
  assign done  = done_r;
  assign pages = quo_r + pfa_pkg::SIZE_W'(rem_r != '0);

endmodule

// File: src/pfa_cell.sv
// One frame of the allocator: free bit, owner tag and owner valid bit, plus
// the token register toward the next cell. Depends on pfa_pkg.
module pfa_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  pfa_pkg::pfa_mode_t          mode,
  input  logic [pfa_pkg::PID_W-1:0]   pid,
  input  logic [pfa_pkg::COUNT_W-1:0] pages_lim,
  input  logic [pfa_pkg::COUNT_W-1:0] n_managed,
  input  pfa_pkg::pfa_link_t          link_in,
  output pfa_pkg::pfa_link_t          link_out,
  output pfa_pkg::pfa_emit_t          emit
);

  localparam bit IN_RANGE = (IDX < int'(pfa_pkg::FRAME_CAP));
  localparam logic [pfa_pkg::COUNT_W-1:0] IDX_C = pfa_pkg::COUNT_W'(IDX);

  logic                      free_r, free_nxt;
  logic                      valid_r, valid_nxt;
  logic [pfa_pkg::PID_W-1:0] owner_r, owner_nxt;
  pfa_pkg::pfa_link_t        out_r, out_nxt;
  logic                      managed;
  logic                      match;
  logic                      grant;

  assign managed = IN_RANGE && (IDX_C < n_managed);
  assign match   = valid_r && (owner_r == pid);
  assign grant   = managed && free_r && (link_in.acc < pages_lim);

  // Work done on this frame as the token passes through.
  always_comb begin
    free_nxt  = free_r;
    valid_nxt = valid_r;
    owner_nxt = owner_r;
    out_nxt   = out_r;
    if (advance) begin
      out_nxt = link_in;
      if (link_in.tok) begin
        case (mode)
          pfa_pkg::MODE_COUNT: begin
            out_nxt.acc = link_in.acc + pfa_pkg::COUNT_W'(free_r && managed);
          end
          pfa_pkg::MODE_FREE: begin
            if (match) begin
              valid_nxt   = 1'b0;
              free_nxt    = 1'b1;
              out_nxt.acc = link_in.acc + 1'b1;
            end
          end
          pfa_pkg::MODE_ALLOC: begin
            // Earlier frames of the same ID lose their owner but stay used.
            if (match) begin
              valid_nxt = 1'b0;
            end
            if (grant) begin
              free_nxt    = 1'b0;
              valid_nxt   = 1'b1;
              owner_nxt   = pid;
              out_nxt.acc = link_in.acc + 1'b1;
            end
          end
          default: begin
            out_nxt = link_in;
          end
        endcase
      end
    end
  end

  // A mapping is raised while the token sits at this cell's input; the
  // payload stays zero otherwise so the chain can OR all cells together.
  always_comb begin
    emit.valid = link_in.tok && (mode == pfa_pkg::MODE_ALLOC) && grant;
    emit.page  = emit.valid ? pfa_pkg::PAGE_W'(link_in.acc) : '0;
    emit.frame = emit.valid ? pfa_pkg::PAGE_W'(IDX) : '0;
    emit.last  = emit.valid && ((link_in.acc + 1'b1) == pages_lim);
  end

  // Control state of the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r  <= 1'b1;
      valid_r <= 1'b0;
      out_r   <= '0;
    end else begin
      free_r  <= free_nxt;
      valid_r <= valid_nxt;
      out_r   <= out_nxt;
    end
  end

  // Owner tag, meaningful only while the valid bit is set.
  always_ff @(posedge clk) begin
    owner_r <= owner_nxt;
  end

  assign link_out = out_r;

endmodule

// File: src/pfa_chain.sv
// Row of frame cells through which a single token walks, one cell per cycle
// unless advance is low. Depends on pfa_pkg and pfa_cell.
module pfa_chain #(
  parameter int MAX_FRAMES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        advance,
  input  pfa_pkg::pfa_mode_t          mode,
  input  logic [pfa_pkg::PID_W-1:0]   pid,
  input  logic [pfa_pkg::COUNT_W-1:0] pages_lim,
  input  logic [pfa_pkg::COUNT_W-1:0] n_managed,
  input  pfa_pkg::pfa_link_t          head,
  output pfa_pkg::pfa_link_t          tail,
  output pfa_pkg::pfa_emit_t          emit
);

  pfa_pkg::pfa_link_t links [MAX_FRAMES+1];
  pfa_pkg::pfa_emit_t cell_emit [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] tok_vec;

  assign links[0] = head;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    pfa_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .mode      (mode),
      .pid       (pid),
      .pages_lim (pages_lim),
      .n_managed (n_managed),
      .link_in   (links[i]),
      .link_out  (links[i+1]),
      .emit      (cell_emit[i])
    );
  end

  assign tail = links[MAX_FRAMES];

  // Only the cell holding the token can raise a mapping, so an OR collects it.
  always_comb begin
    emit = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      emit = pfa_pkg::pfa_emit_t'(emit | cell_emit[i]);
    end
  end

  // Token positions, used by the checks below.
  always_comb begin
    for (int i = 0; i < MAX_FRAMES; i++) begin
      tok_vec[i] = links[i+1].tok;
    end
  end

`ifndef NO_ASSERTIONS
  // At most one token walks the chain.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one token in the frame chain");

  // Mappings are raised only by an allocating walk.
  a_emit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    emit.valid |-> (mode == pfa_pkg::MODE_ALLOC))
    else $error("mapping raised outside an allocating walk");

  // Once the token leaves the last cell the chain is empty.
  a_tail_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.tok && advance) |=> (tok_vec == '0))
    else $error("token left behind after walk completed");
`endif

endmodule

// File: src/page_frame_allocator.sv
// Page frame allocator with a free bit and owner tag per physical frame.
// Depends on pfa_pkg, the channel interfaces, pfa_div and pfa_chain.
//
// Usage: requests arrive on in_if (valid/ready); an allocate request maps
// ceil(memory_size / frame_bytes) logical pages onto the lowest free frames
// and returns one mapping transaction per page on out_if, the final one with
// last set. A failed allocate, an empty allocate and a free each return one
// transaction with last set. cfg_if writes frame_bytes (index 0) and
// frames_in_use (index 1) and is always ready; write it only while idle.
// Timing: one request at a time. A free walks the frame chain once. An
// allocate runs the divider alongside a counting walk, then walks the chain
// again to place pages; a failed allocate skips that second walk. Each walk
// passes one frame cell per cycle unless out_if stalls the allocating walk.
// When out_if stalls, the allocating walk holds in place; the output register
// keeps the waiting transaction so the next request can still be accepted.
// Reset marks every frame free with no owner and restores frame_bytes to 16
// and frames_in_use to 64.
module page_frame_allocator #(
  parameter int MAX_FRAMES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  pfa_in_if.sink    in_if,
  pfa_out_if.source out_if,
  pfa_cfg_if.sink   cfg_if
);

  localparam logic [pfa_pkg::COUNT_W-1:0] CAP_C =
    (MAX_FRAMES < int'(pfa_pkg::FRAME_CAP)) ? pfa_pkg::COUNT_W'(MAX_FRAMES)
                                            : pfa_pkg::FRAME_CAP;

  pfa_pkg::pfa_state_t state_r, state_nxt;
  pfa_pkg::pfa_mode_t  mode_r, mode_nxt;
  pfa_pkg::pfa_link_t  head_r, head_nxt;

  logic [pfa_pkg::FBYTES_W-1:0] fbytes_r;
  logic [pfa_pkg::COUNT_W-1:0]  fiu_r;
  logic [pfa_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic [pfa_pkg::COUNT_W-1:0]  lim_r, lim_nxt;
  logic [pfa_pkg::COUNT_W-1:0]  avail_r, avail_nxt;
  logic                         avail_ok_r, avail_ok_nxt;
  logic                         empty_r, empty_nxt;
  logic [pfa_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [pfa_pkg::COUNT_W-1:0]  res_count_r, res_count_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [pfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pfa_pkg::PAGE_W-1:0]   out_page_r, out_page_nxt;
  logic [pfa_pkg::PAGE_W-1:0]   out_frame_r, out_frame_nxt;
  logic [pfa_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [pfa_pkg::COUNT_W-1:0]  n_managed;
  logic [pfa_pkg::FBYTES_W-1:0] fb_eff;
  logic                         in_accept;
  logic                         slot_ok;
  logic                         advance;
  logic                         div_start;
  logic                         div_done;
  logic [pfa_pkg::SIZE_W-1:0]   div_pages;
  pfa_pkg::pfa_link_t           tail;
  pfa_pkg::pfa_emit_t           chain_emit;

  // Configuration writes.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fbytes_r <= pfa_pkg::FRAME_BYTES_RST;
      fiu_r    <= pfa_pkg::FRAMES_IN_USE_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        pfa_pkg::CFG_FRAME_BYTES:   fbytes_r <= cfg_if.data;
        pfa_pkg::CFG_FRAMES_IN_USE: fiu_r    <= cfg_if.data[pfa_pkg::COUNT_W-1:0];
        default:                    fbytes_r <= fbytes_r;
      endcase
    end
  end

  // Effective frame size and managed frame count.
  assign fb_eff    = (fbytes_r == '0) ? pfa_pkg::FBYTES_W'(1) : fbytes_r;
  assign n_managed = (fiu_r > CAP_C) ? CAP_C : fiu_r;

  // Handshake helpers; the walk holds while a mapping cannot be stored.
  assign in_if.ready = (state_r == pfa_pkg::ST_IDLE);
  assign in_accept   = in_if.valid && in_if.ready;
  assign slot_ok     = !out_valid_r || out_if.ready;
  assign advance     = !(chain_emit.valid && !slot_ok);
  assign div_start   = in_accept && (in_if.operation == pfa_pkg::OP_ALLOC);

  pfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_if.memory_size),
    .divisor  (fb_eff),
    .done     (div_done),
    .pages    (div_pages)
  );

  pfa_chain #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .mode      (mode_r),
    .pid       (pid_r),
    .pages_lim (lim_r),
    .n_managed (n_managed),
    .head      (head_r),
    .tail      (tail),
    .emit      (chain_emit)
  );

  // Controller: sequences the walks and the single-result transactions.
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    pid_nxt        = pid_r;
    lim_nxt        = lim_r;
    avail_nxt      = avail_r;
    avail_ok_nxt   = avail_ok_r;
    empty_nxt      = empty_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    head_nxt       = advance ? '0 : head_r;
    case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (in_accept) begin
          pid_nxt       = in_if.process_id;
          head_nxt.tok  = 1'b1;
          head_nxt.acc  = '0;
          avail_ok_nxt  = 1'b0;
          if (in_if.operation == pfa_pkg::OP_FREE) begin
            mode_nxt  = pfa_pkg::MODE_FREE;
            state_nxt = pfa_pkg::ST_WAVE;
          end else begin
            mode_nxt  = pfa_pkg::MODE_COUNT;
            state_nxt = pfa_pkg::ST_PREP;
          end
        end
      end
      pfa_pkg::ST_PREP: begin
        // Wait for both the free count and the page count.
        if (tail.tok) begin
          avail_nxt    = tail.acc;
          avail_ok_nxt = 1'b1;
        end
        if (avail_ok_r && div_done) begin
          if (div_pages == '0) begin
            mode_nxt     = pfa_pkg::MODE_ALLOC;
            lim_nxt      = '0;
            empty_nxt    = 1'b1;
            head_nxt.tok = 1'b1;
            head_nxt.acc = '0;
            state_nxt    = pfa_pkg::ST_WAVE;
          end else if (div_pages > pfa_pkg::SIZE_W'(avail_r)) begin
            res_status_nxt = pfa_pkg::STATUS_FAIL;
            res_count_nxt  = '0;
            state_nxt      = pfa_pkg::ST_EMIT;
          end else begin
            mode_nxt     = pfa_pkg::MODE_ALLOC;
            lim_nxt      = pfa_pkg::COUNT_W'(div_pages);
            empty_nxt    = 1'b0;
            head_nxt.tok = 1'b1;
            head_nxt.acc = '0;
            state_nxt    = pfa_pkg::ST_WAVE;
          end
        end
      end
      pfa_pkg::ST_WAVE: begin
        if (tail.tok) begin
          if (mode_r == pfa_pkg::MODE_FREE) begin
            res_status_nxt = pfa_pkg::STATUS_FREED;
            res_count_nxt  = tail.acc;
            state_nxt      = pfa_pkg::ST_EMIT;
          end else if (empty_r) begin
            res_status_nxt = pfa_pkg::STATUS_EMPTY;
            res_count_nxt  = '0;
            state_nxt      = pfa_pkg::ST_EMIT;
          end else begin
            state_nxt = pfa_pkg::ST_IDLE;
          end
        end
      end
      pfa_pkg::ST_EMIT: begin
        if (slot_ok) begin
          state_nxt = pfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register, loaded from the chain or from the controller.
  always_comb begin
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_page_nxt   = out_page_r;
    out_frame_nxt  = out_frame_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (chain_emit.valid && slot_ok) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pfa_pkg::STATUS_MAP;
      out_page_nxt   = chain_emit.page;
      out_frame_nxt  = chain_emit.frame;
      out_count_nxt  = '0;
      out_last_nxt   = chain_emit.last;
    end else if ((state_r == pfa_pkg::ST_EMIT) && slot_ok) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_page_nxt   = '0;
      out_frame_nxt  = '0;
      out_count_nxt  = res_count_r;
      out_last_nxt   = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::ST_IDLE;
      mode_r      <= pfa_pkg::MODE_COUNT;
      head_r      <= '0;
      avail_ok_r  <= 1'b0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      head_r      <= head_nxt;
      avail_ok_r  <= avail_ok_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pid_r        <= pid_nxt;
    lim_r        <= lim_nxt;
    avail_r      <= avail_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    out_status_r <= out_status_nxt;
    out_page_r   <= out_page_nxt;
    out_frame_r  <= out_frame_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = out_status_r;
  assign out_if.logical_page = out_page_r;
  assign out_if.frame_number = out_frame_r;
  assign out_if.freed_count  = out_count_r;
  assign out_if.last         = out_last_r;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for page_frame_allocator: random and directed allocate and free
// requests, a cycle-free prediction of the frame table, and per-field result checks.
// Depends on pfa_pkg, the three channel interfaces and the page_frame_allocator RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_FRAMES     = 64;
  localparam int POOL_SIZE      = 8;
  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 55;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic                       op;
    logic [pfa_pkg::PID_W-1:0]  pid;
    logic [pfa_pkg::SIZE_W-1:0] size;
  } request_t;

  typedef struct packed {
    logic [pfa_pkg::STATUS_W-1:0] status;
    logic [pfa_pkg::PAGE_W-1:0]   page;
    logic [pfa_pkg::PAGE_W-1:0]   frame;
    logic [pfa_pkg::COUNT_W-1:0]  freed;
    logic                         last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pfa_in_if  in_bus();
  pfa_out_if out_bus();
  pfa_cfg_if cfg_bus();

  page_frame_allocator #(.MAX_FRAMES(NUM_FRAMES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  // Shadow copy of the registers and the frame table.
  logic [pfa_pkg::FBYTES_W-1:0] cfg_frame_bytes;
  logic [pfa_pkg::COUNT_W-1:0]  cfg_frames_in_use;
  logic                         frame_free  [NUM_FRAMES];
  logic [pfa_pkg::PID_W-1:0]    frame_owner [NUM_FRAMES];
  logic                         owner_valid [NUM_FRAMES];

  request_t      request_q[$];
  frame_result_t frame_results_q[$];

  // Process IDs used by the random part and whether each one holds frames.
  logic [pfa_pkg::PID_W-1:0] pid_pool [POOL_SIZE];
  logic                      pid_live [POOL_SIZE];

  bit in_gaps_on;
  bit out_stalls_on;
  int drv_wait;
  int mon_wait;
  int idle_cycles;
  int queued_count;
  int req_count;
  int fail_count;
  int map_count;
  int oom_count;
  int empty_count;
  int release_count;
  int setting_count;

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append one expected result transaction.
  task automatic push_result(input logic [pfa_pkg::STATUS_W-1:0] st,
                             input int unsigned page, input int unsigned frame,
                             input int unsigned count, input logic last);
    frame_result_t r;
    r.status = st;
    r.page   = page[pfa_pkg::PAGE_W-1:0];
    r.frame  = frame[pfa_pkg::PAGE_W-1:0];
    r.freed  = count[pfa_pkg::COUNT_W-1:0];
    r.last   = last;
    frame_results_q.push_back(r);
  endtask

  // Frames still owned by this ID lose their owner but stay in use.
  task automatic orphan_frames(input logic [pfa_pkg::PID_W-1:0] pid);
    for (int i = 0; i < NUM_FRAMES; i++)
      if (owner_valid[i] && frame_owner[i] == pid) owner_valid[i] = 1'b0;
  endtask

  // Update the frame table for one accepted request and queue its results.
  task automatic apply_request(input request_t req);
    int unsigned fb;
    int unsigned pages;
    int unsigned limit;
    int unsigned avail;
    int unsigned k;
    int unsigned released;
    if (req.op == pfa_pkg::OP_FREE) begin
      // A free scans the whole table, also past the managed count.
      released = 0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (owner_valid[i] && frame_owner[i] == req.pid) begin
          owner_valid[i] = 1'b0;
          frame_free[i]  = 1'b1;
          released++;
        end
      end
      push_result(pfa_pkg::STATUS_FREED, 0, 0, released, 1'b1);
    end else begin
      // A frame size of zero behaves as one byte.
      fb    = (cfg_frame_bytes == '0) ? 1 : cfg_frame_bytes;
      pages = (req.size + fb - 1) / fb;
      limit = (cfg_frames_in_use > NUM_FRAMES) ? NUM_FRAMES : cfg_frames_in_use;
      avail = 0;
      for (int i = 0; i < limit; i++)
        if (frame_free[i]) avail++;
      if (pages == 0) begin
        orphan_frames(req.pid);
        push_result(pfa_pkg::STATUS_EMPTY, 0, 0, 0, 1'b1);
      end else if (avail < pages) begin
        push_result(pfa_pkg::STATUS_FAIL, 0, 0, 0, 1'b1);
      end else begin
        orphan_frames(req.pid);
        k = 0;
        for (int i = 0; i < limit && k < pages; i++) begin
          if (frame_free[i]) begin
            frame_free[i]  = 1'b0;
            frame_owner[i] = req.pid;
            owner_valid[i] = 1'b1;
            push_result(pfa_pkg::STATUS_MAP, k, i, 0, (k + 1 == pages));
            k++;
          end
        end
      end
    end
  endtask

  task automatic queue_request(input logic op, input logic [pfa_pkg::PID_W-1:0] pid,
                               input logic [pfa_pkg::SIZE_W-1:0] size);
    request_t r;
    r.op   = op;
    r.pid  = pid;
    r.size = size;
    request_q.push_back(r);
    queued_count++;
  endtask

  // Mostly well-formed traffic: an ID allocates while it holds nothing and
  // frees once it does, with a little noise and a rare reuse of a live ID.
  task automatic queue_random(input int count);
    int unsigned fb_eff;
    int unsigned pages;
    int unsigned roll;
    int unsigned slot;
    logic [pfa_pkg::SIZE_W-1:0] sz;
    fb_eff = (cfg_frame_bytes == '0) ? 1 : cfg_frame_bytes;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (roll < 6) begin
        // Free of an arbitrary ID, which normally owns nothing.
        queue_request(pfa_pkg::OP_FREE, pfa_pkg::PID_W'($urandom),
                      pfa_pkg::SIZE_W'($urandom));
      end else if (roll == 6) begin
        // Reuse of an ID: orphaned frames never come back, so this stays rare.
        queue_request(pfa_pkg::OP_ALLOC, pid_pool[slot],
                      pfa_pkg::SIZE_W'($urandom_range(0, 3 * fb_eff)));
        pid_live[slot] = 1'b1;
      end else if (pid_live[slot]) begin
        queue_request(pfa_pkg::OP_FREE, pid_pool[slot], pfa_pkg::SIZE_W'($urandom));
        pid_live[slot] = 1'b0;
      end else begin
        if (roll < 14) begin
          sz = pfa_pkg::SIZE_W'($urandom);
        end else begin
          pages = ($urandom_range(0, 19) == 0) ? $urandom_range(13, NUM_FRAMES)
                                                : $urandom_range(0, 12);
          sz = (pages == 0) ? '0
                            : pfa_pkg::SIZE_W'((pages - 1) * fb_eff +
                                               $urandom_range(1, fb_eff));
        end
        queue_request(pfa_pkg::OP_ALLOC, pid_pool[slot], sz);
        pid_live[slot] = 1'b1;
      end
    end
  endtask

  // One register write on the configuration channel.
  task automatic write_register(input logic idx,
                                input logic [pfa_pkg::FBYTES_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx == pfa_pkg::CFG_FRAME_BYTES) cfg_frame_bytes = value;
    else cfg_frames_in_use = value[pfa_pkg::COUNT_W-1:0];
    cfg_bus.valid <= 1'b0;
  endtask

  // Wait until every queued request is accepted and all its results are back.
  task automatic wait_drained();
    @(posedge clk);
    while (req_count != queued_count || frame_results_q.size() != 0) @(posedge clk);
  endtask

  // Request driver: presents queued requests with a random gap after each one.
  always @(posedge clk) begin
    request_t nxt;
    logic     taken;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      drv_wait     <= 0;
    end else begin
      taken = in_bus.valid && in_bus.ready;
      if (taken) begin
        nxt.op   = in_bus.operation;
        nxt.pid  = in_bus.process_id;
        nxt.size = in_bus.memory_size;
        apply_request(nxt);
        req_count++;
      end
      if (!in_bus.valid || taken) begin
        if (drv_wait > 0) begin
          drv_wait     <= drv_wait - 1;
          in_bus.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_bus.valid       <= 1'b1;
          in_bus.operation   <= nxt.op;
          in_bus.process_id  <= nxt.pid;
          in_bus.memory_size <= nxt.size;
          drv_wait           <= in_gaps_on ? $urandom_range(0, 15) : 0;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation
  // and stalls the channel for a random number of cycles after it.
  always @(posedge clk) begin
    frame_result_t want;
    int            stall_len;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      mon_wait      <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      if (frame_results_q.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_bus.status);
        fail_count++;
      end else begin
        want = frame_results_q.pop_front();
        if (out_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_bus.status);
          fail_count++;
        end
        if (out_bus.logical_page !== want.page) begin
          $error("logical_page: expected %0d, got %0d", want.page, out_bus.logical_page);
          fail_count++;
        end
        if (out_bus.frame_number !== want.frame) begin
          $error("frame_number: expected %0d, got %0d", want.frame, out_bus.frame_number);
          fail_count++;
        end
        if (out_bus.freed_count !== want.freed) begin
          $error("freed_count: expected %0d, got %0d", want.freed, out_bus.freed_count);
          fail_count++;
        end
        if (out_bus.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_bus.last);
          fail_count++;
        end
        case (want.status)
          pfa_pkg::STATUS_MAP:   map_count++;
          pfa_pkg::STATUS_FAIL:  oom_count++;
          pfa_pkg::STATUS_EMPTY: empty_count++;
          default:               release_count++;
        endcase
      end
      stall_len = out_stalls_on ? $urandom_range(0, 15) : 0;
      if (stall_len > 0) begin
        out_bus.ready <= 1'b0;
        mon_wait      <= stall_len - 1;
      end
    end else if (!out_bus.ready) begin
      if (mon_wait > 0) mon_wait <= mon_wait - 1;
      else out_bus.ready <= 1'b1;
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                 (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence: reset, directed requests, then random phases under several settings.
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.operation    = pfa_pkg::OP_ALLOC;
    in_bus.process_id   = '0;
    in_bus.memory_size  = '0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = pfa_pkg::CFG_FRAME_BYTES;
    cfg_bus.data        = '0;
    cfg_frame_bytes     = pfa_pkg::FRAME_BYTES_RST;
    cfg_frames_in_use   = pfa_pkg::FRAMES_IN_USE_RST;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      frame_free[i]  = 1'b1;
      frame_owner[i] = '0;
      owner_valid[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) begin
      pid_pool[i] = pfa_pkg::PID_W'($urandom);
      pid_live[i] = 1'b0;
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    setting_count = 1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings: empty allocation, unknown ID,
    // rounding of the page count, reuse of an ID, failed allocation leaving
    // state alone, orphaned frames blocking a full allocation, field extremes.
    queue_request(pfa_pkg::OP_ALLOC, 16'd2, 24'd0);
    queue_request(pfa_pkg::OP_FREE,  16'd1, 24'd0);
    queue_request(pfa_pkg::OP_ALLOC, 16'd2, 24'd16);
    queue_request(pfa_pkg::OP_ALLOC, 16'd3, 24'd17);
    queue_request(pfa_pkg::OP_ALLOC, 16'd1, 24'd1);
    queue_request(pfa_pkg::OP_ALLOC, 16'd1, 24'd32);
    queue_request(pfa_pkg::OP_ALLOC, 16'd5, 24'd16);
    queue_request(pfa_pkg::OP_ALLOC, 16'd5, 24'd0);
    queue_request(pfa_pkg::OP_FREE,  16'd5, 24'hFFFFFF);
    queue_request(pfa_pkg::OP_ALLOC, 16'd6, 24'd16);
    queue_request(pfa_pkg::OP_ALLOC, 16'd6, 24'hFFFFFF);
    queue_request(pfa_pkg::OP_FREE,  16'd6, 24'd0);
    queue_request(pfa_pkg::OP_FREE,  16'd1, 24'd0);
    queue_request(pfa_pkg::OP_FREE,  16'd2, 24'd0);
    queue_request(pfa_pkg::OP_FREE,  16'd3, 24'd0);
    queue_request(pfa_pkg::OP_ALLOC, 16'hFFFF, 24'd1024);
    queue_request(pfa_pkg::OP_ALLOC, 16'hFFFF, 24'd992);
    queue_request(pfa_pkg::OP_ALLOC, 16'd0, 24'd1);
    queue_request(pfa_pkg::OP_FREE,  16'hFFFF, 24'd0);
    queue_request(pfa_pkg::OP_ALLOC, 16'd0, 24'd1);
    queue_request(pfa_pkg::OP_FREE,  16'd0, 24'd0);
    queue_request(pfa_pkg::OP_ALLOC, 16'h8000, 24'h800000);
    queue_request(pfa_pkg::OP_FREE,  16'hABCD, 24'h5A5A5A);
    wait_drained();

    // Random phases, each under its own register settings.
    for (int p = 0; p < NUM_PHASES; p++) begin
      repeat (SETTLE_CYCLES) @(posedge clk);
      case (p)
        0: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd16);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd64);
        end
        1: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd0);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd64);
        end
        2: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'hFFFF);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd127);
        end
        3: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd1);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd0);
        end
        4: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd100);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd65);
        end
        5: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd7);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd1);
        end
        6: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES,
                         pfa_pkg::FBYTES_W'($urandom_range(1, 300)));
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd8);
        end
        7: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, 16'd48);
          write_register(pfa_pkg::CFG_FRAMES_IN_USE, 16'd64);
        end
        default: begin
          write_register(pfa_pkg::CFG_FRAME_BYTES, pfa_pkg::FBYTES_W'($urandom));
          write_register(pfa_pkg::CFG_FRAMES_IN_USE,
                         pfa_pkg::FBYTES_W'($urandom_range(1, 64)));
        end
      endcase
      setting_count++;
      // The first phase runs back to back on both sides.
      in_gaps_on    = (p != 0) && ($urandom_range(0, 3) != 0);
      out_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
      queue_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      $error("%0d expected results never arrived", frame_results_q.size());
      fail_count++;
    end
    $display("Ran %0d requests under %0d register settings.", req_count, setting_count);
    $display("Saw %0d page mappings, %0d out-of-frame, %0d empty and %0d free results.",
             map_count, oom_count, empty_count, release_count);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
src/pfa_pkg.sv
src/pfa_in_if.sv
src/pfa_out_if.sv
src/pfa_cfg_if.sv
src/pfa_div.sv
src/pfa_cell.sv
src/pfa_chain.sv
src/page_frame_allocator.sv
tb/tb_top.sv
